// ----- hw/rtl/linear_convolution_engine_macros.svh -----
// Assertion macros for the linear convolution engine.
`ifndef LINEAR_CONVOLUTION_ENGINE_MACROS_SVH
`define LINEAR_CONVOLUTION_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lce_pkg.sv -----
// Package: constants, codes and types of the linear convolution engine.
package lce_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int IDX_W       = $clog2(MAX_TAPS);
    localparam int CNT_W       = $clog2(MAX_TAPS + 1);
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS);
    localparam int SHR_W       = ACC_W - FRAC_BITS;

    localparam logic [CNT_W-1:0]        TAPS_FULL = CNT_W'(MAX_TAPS);
    localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [SHR_W-1:0] SMAX_EXT  = SHR_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [SHR_W-1:0] SMIN_EXT  = -SHR_W'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_END   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

// ----- hw/rtl/linear_convolution_engine.sv -----
// Top level: direct-form FIR convolution engine over tap and delay-line memories.
//
//   channel   dir  tdata            tuser          tlast
//   s_axis    in   value[23:0]      cmd[1:0]       -
//   m_axis    out  out_sample[23:0] saturated[0]   last tail word
//
// A sample word runs through the accept step, one multiply-accumulate per tap
// through the single shared multiplier, a drain of the read and product
// registers and one emit (only accept and emit with no taps). An end word
// runs tap_count-1 steps of multiply-accumulate, drain and emit.
// Reset clears tap count, write pointer and the delay-line valid bits; no
// clearing pass. A stalled output holds the engine in its emit step only.
`include "linear_convolution_engine_macros.svh"

module linear_convolution_engine
    import lce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [23:0] value
    input  logic [1:0]             s_axis_tuser,   // [1:0] cmd
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [SAMPLE_BITS-1:0] m_axis_tdata,   // [23:0] out_sample
    output logic                   m_axis_tuser,   // [0] saturated
    output logic                   m_axis_tlast
);

    // Memories: taps and delay line, registered read.
    logic [SAMPLE_BITS-1:0] tap_mem [MAX_TAPS];
    logic [SAMPLE_BITS-1:0] dly_mem [MAX_TAPS];

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       tap_count_reg;
    logic [IDX_W-1:0]       wp_reg;
    logic [MAX_TAPS-1:0]    dly_valid_reg;   // entry not valid reads as zero
    logic [IDX_W-1:0]       k_reg;           // tap index being issued
    logic                   tail_reg;        // working through an end word
    logic [IDX_W-1:0]       tail_left_reg;   // tail steps still to emit

    logic                   rd_vld_reg;
    logic [SAMPLE_BITS-1:0] tap_rd_reg;
    logic [SAMPLE_BITS-1:0] dly_rd_reg;
    logic                   dly_ok_reg;
    logic                   prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                   in_fire;
    cmd_t                   in_cmd;
    logic [IDX_W-1:0]       rd_addr;
    logic                   last_issue;
    logic                   out_free;
    logic                   tail_done;
    logic signed [SAMPLE_BITS-1:0] dly_op;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [SHR_W-1:0]  shr;
    logic [SAMPLE_BITS-1:0]   sat_val;
    logic                     sat_flag;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = cmd_t'(s_axis_tuser);
    assign rd_addr       = wp_reg - k_reg;
    assign last_issue    = ({1'b0, k_reg} == (tap_count_reg - CNT_W'(1)));
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign tail_done     = tail_reg && (tail_left_reg == IDX_W'(1));
    assign dly_op        = dly_ok_reg ? signed'(dly_rd_reg) : '0;

    // Round half up, then clip to Q1.23.
    always_comb
    begin
        rnd      = acc_reg + RND_HALF;
        shr      = rnd[ACC_W-1:FRAC_BITS];
        sat_flag = 1'b0;
        sat_val  = shr[SAMPLE_BITS-1:0];
        if (shr > SMAX_EXT)
        begin
            sat_val  = SMAX_EXT[SAMPLE_BITS-1:0];
            sat_flag = 1'b1;
        end
        else if (shr < SMIN_EXT)
        begin
            sat_val  = SMIN_EXT[SAMPLE_BITS-1:0];
            sat_flag = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_cmd == CMD_PUSH)
                begin
                    state_next = (tap_count_reg == '0) ? ST_EMIT : ST_MAC;
                end
                else if (in_fire && in_cmd == CMD_END && tap_count_reg > CNT_W'(1))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (tail_reg && !tail_done) ? ST_MAC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= '0;
            wp_reg        <= '0;
            dly_valid_reg <= '0;
            k_reg         <= '0;
            tail_reg      <= 1'b0;
            tail_left_reg <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= (state_reg == ST_MAC);
            prod_vld_reg <= rd_vld_reg;
            if (state_reg == ST_MAC)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                m_axis_tvalid <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        k_reg <= '0;
                        unique case (in_cmd)
                            CMD_LOAD:
                            begin
                                if (tap_count_reg != TAPS_FULL)
                                begin
                                    tap_count_reg <= tap_count_reg + CNT_W'(1);
                                end
                            end
                            CMD_PUSH:
                            begin
                                tail_reg              <= 1'b0;
                                dly_valid_reg[wp_reg] <= 1'b1;
                            end
                            CMD_END:
                            begin
                                if (tap_count_reg > CNT_W'(1))
                                begin
                                    tail_reg              <= 1'b1;
                                    tail_left_reg         <= IDX_W'(tap_count_reg - CNT_W'(1));
                                    dly_valid_reg[wp_reg] <= 1'b0;
                                end
                                else
                                begin
                                    dly_valid_reg <= '0;
                                    wp_reg        <= '0;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                tap_count_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        k_reg <= '0;
                        if (tail_done)
                        begin
                            // Tail finished: empty the delay line.
                            tail_reg      <= 1'b0;
                            dly_valid_reg <= '0;
                            wp_reg        <= '0;
                        end
                        else
                        begin
                            wp_reg <= wp_reg + IDX_W'(1);
                            if (tail_reg)
                            begin
                                tail_left_reg                         <= tail_left_reg - IDX_W'(1);
                                dly_valid_reg[wp_reg + IDX_W'(1)]     <= 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Tap memory: write on load, read at the issued tap index.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_cmd == CMD_LOAD && tap_count_reg != TAPS_FULL)
        begin
            tap_mem[tap_count_reg[IDX_W-1:0]] <= s_axis_tdata;
        end
        tap_rd_reg <= tap_mem[k_reg];
    end

    // Delay memory: write on sample, read newest-first from the write pointer.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_cmd == CMD_PUSH)
        begin
            dly_mem[wp_reg] <= s_axis_tdata;
        end
        dly_rd_reg <= dly_mem[rd_addr];
        dly_ok_reg <= dly_valid_reg[rd_addr];
    end

    // Multiply, accumulate and output payload.
    always_ff @(posedge clk)
    begin
        prod_reg <= signed'(tap_rd_reg) * dly_op;
        if ((state_reg == ST_IDLE) || (state_reg == ST_EMIT && out_free))
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            m_axis_tdata <= sat_val;
            m_axis_tuser <= sat_flag;
            m_axis_tlast <= tail_done;
        end
    end

    `LCE_ASSERT_SAME(a_cnt_range, 1'b1, tap_count_reg <= TAPS_FULL, "tap count beyond capacity")
    `LCE_ASSERT_SAME(a_idle_pipe, in_fire, !rd_vld_reg && !prod_vld_reg, "word taken with MAC in flight")
    `LCE_ASSERT_NEXT(a_tail_flush, state_reg == ST_EMIT && out_free && tail_done,
                     wp_reg == '0 && dly_valid_reg == '0 && m_axis_tlast, "tail end did not flush")

endmodule
